@@ rtl/lzss_fbd_pkg.sv @@
// Package for the LZSS flag-byte decoder: request and response payload types,
// status codes, register indexes and the token key table.
// Depends on nothing; the decoder top level imports it.
package lzss_fbd_pkg;

   localparam int WINDOW_DEPTH    = 4096;
   localparam int WIN_AW          = $clog2(WINDOW_DEPTH);
   localparam int COUNT_W         = 29;
   localparam int MAX_OUTPUT_SIZE = 268435456;
   localparam int CSR_IDX_W       = 2;

   localparam logic [COUNT_W-1:0] MAX_OUTPUT_CNT = COUNT_W'(MAX_OUTPUT_SIZE);

   localparam logic [7:0]  FLAG_KEY       = 8'hC8;
   localparam logic [15:0] TOKEN_OFF_MASK = 16'h0FFF;
   localparam logic [2:0]  KEY_SEL_MASK   = 3'h7;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KEYED_MODE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_SIZE = CSR_IDX_W'(1);

   // Final status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SIZE     = 2'd1;
   localparam logic [1:0] ST_OFFSET   = 2'd2;
   localparam logic [1:0] ST_TRUNC    = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       done_res;
      logic [1:0] status;
   } rsp_data_type;

   function automatic logic [15:0] key_word(input logic [2:0] sel);
      logic [15:0] word;
      case (sel)
         3'd0:    word = 16'hFF21;
         3'd1:    word = 16'h834F;
         3'd2:    word = 16'h675F;
         3'd3:    word = 16'h0034;
         3'd4:    word = 16'hF237;
         3'd5:    word = 16'h815F;
         3'd6:    word = 16'h4765;
         default: word = 16'h0233;
      endcase
      return word;
   endfunction

endpackage

@@ rtl/lzss_flag_byte_decoder.sv @@
// LZSS flag-byte decoder with a 4096-byte history window held in a local memory.
// Depends on lzss_fbd_pkg for payload types, codes and the token key table.
//
// One compressed byte enters per request. A flag byte, a literal or the low byte
// of a token is taken in the idle state; the response to a literal is registered
// and appears in the cycle after. The high byte of a token starts a copy of
// length+2 bytes that runs through the single-port history memory, each byte read
// in S_READ and then emitted and written back in S_EMIT, and req_stall stays high
// from the cycle after its high byte is taken until the last copied byte has been
// emitted. A response waiting in the output register stalls the decoder until it
// is taken. The history needs no clearing pass after reset, since offsets never
// reach past the bytes decoded in the current stream.
// Configuration writes are always accepted and take effect at the next use.
module lzss_flag_byte_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lzss_fbd_pkg::req_data_type         req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lzss_fbd_pkg::rsp_data_type         rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lzss_fbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lzss_fbd_pkg::COUNT_W-1:0]   csr_data
);
   import lzss_fbd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_ELEM,
      PH_TOKHI,
      PH_SPARE
   } phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [7:0]          flag_shift_ff, flag_shift_in;
   logic [7:0]          raw_flag_ff, raw_flag_in;
   logic [2:0]          pos_ff, pos_in;
   logic [7:0]          tok_lo_ff, tok_lo_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [1:0]          error_ff, error_in;
   logic                stopped_ff, stopped_in;
   logic                keyed_ff, keyed_in;
   logic [COUNT_W-1:0]  expected_ff, expected_in;
   logic [WIN_AW-1:0]   src_ff, src_in;
   logic [4:0]          remain_ff, remain_in;
   logic                last_pend_ff, last_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;

   logic [7:0]          hist_mem [WINDOW_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                hist_we;
   logic [7:0]          hist_wdata;

   logic                out_free;
   logic                req_accept;
   logic [COUNT_W-1:0]  limit;
   logic [COUNT_W-1:0]  end_count;
   logic                over;
   logic                size_bad;
   logic [15:0]         token;
   logic [11:0]         offset;
   logic                bad_offset;
   logic                end_elem;
   logic                clear_stream;
   logic                res_load;
   logic [7:0]          res_byte;
   logic                res_bv;
   logic                res_run_last;
   logic                res_done;
   logic [1:0]          res_status;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Element-end checks; the count always advances by exactly one byte here.
   assign limit     = (expected_ff > MAX_OUTPUT_CNT) ? MAX_OUTPUT_CNT : expected_ff;
   assign end_count = count_ff + COUNT_W'(1);
   assign over      = end_count > limit;
   assign size_bad  = over || (end_count != expected_ff);

   always_comb begin
      token = {req_data.in_byte, tok_lo_ff};
      if (keyed_ff) begin
         token = token ^ key_word(raw_flag_ff[5:3] & KEY_SEL_MASK);
      end
   end

   assign offset     = 12'(token & TOKEN_OFF_MASK);
   assign bad_offset = (offset == 12'd0) || ({{(COUNT_W-12){1'b0}}, offset} > count_ff);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      flag_shift_in = flag_shift_ff;
      raw_flag_in   = raw_flag_ff;
      pos_in        = pos_ff;
      tok_lo_in     = tok_lo_ff;
      count_in      = count_ff;
      error_in      = error_ff;
      stopped_in    = stopped_ff;
      keyed_in      = keyed_ff;
      expected_in   = expected_ff;
      src_in        = src_ff;
      remain_in     = remain_ff;
      last_pend_in  = last_pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      hist_we       = 1'b0;
      hist_wdata    = rd_data_ff;
      end_elem      = 1'b0;
      clear_stream  = 1'b0;
      res_load      = 1'b0;
      res_byte      = 8'd0;
      res_bv        = 1'b0;
      res_run_last  = 1'b1;
      res_done      = 1'b0;
      res_status    = ST_OK;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEYED_MODE:    keyed_in    = csr_data[0];
            CSR_EXPECTED_SIZE: expected_in = csr_data;
            default:           ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (stopped_ff) begin
                  if (req_data.in_last) begin
                     res_load     = 1'b1;
                     res_done     = 1'b1;
                     res_status   = error_ff;
                     clear_stream = 1'b1;
                  end
               end else begin
                  case (phase_ff)
                     PH_ELEM: begin
                        if (flag_shift_ff[0]) begin
                           tok_lo_in = req_data.in_byte;
                           phase_in  = PH_TOKHI;
                           if (req_data.in_last) begin
                              res_load     = 1'b1;
                              res_done     = 1'b1;
                              res_status   = ST_TRUNC;
                              clear_stream = 1'b1;
                           end
                        end else begin
                           res_load   = 1'b1;
                           res_byte   = req_data.in_byte;
                           res_bv     = 1'b1;
                           res_done   = req_data.in_last;
                           res_status = size_bad ? ST_SIZE : ST_OK;
                           hist_we    = 1'b1;
                           hist_wdata = req_data.in_byte;
                           count_in   = end_count;
                           end_elem   = 1'b1;
                           clear_stream = req_data.in_last;
                        end
                     end
                     PH_TOKHI: begin
                        if (bad_offset) begin
                           stopped_in = 1'b1;
                           error_in   = ST_OFFSET;
                           if (req_data.in_last) begin
                              res_load     = 1'b1;
                              res_done     = 1'b1;
                              res_status   = ST_OFFSET;
                              clear_stream = 1'b1;
                           end
                        end else begin
                           src_in       = count_ff[WIN_AW-1:0] - offset;
                           remain_in    = {1'b0, token[15:12]} + 5'd1;
                           last_pend_in = req_data.in_last;
                           state_in     = S_READ;
                        end
                     end
                     default: begin
                        raw_flag_in   = req_data.in_byte;
                        flag_shift_in = keyed_ff ? (req_data.in_byte ^ FLAG_KEY)
                                                 : req_data.in_byte;
                        pos_in        = 3'd0;
                        phase_in      = PH_ELEM;
                        if (req_data.in_last) begin
                           res_load     = 1'b1;
                           res_done     = 1'b1;
                           res_status   = (count_ff != expected_ff) ? ST_SIZE : ST_OK;
                           clear_stream = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         S_READ: begin
            src_in   = src_ff + WIN_AW'(1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               res_load   = 1'b1;
               res_byte   = rd_data_ff;
               res_bv     = 1'b1;
               hist_we    = 1'b1;
               hist_wdata = rd_data_ff;
               count_in   = end_count;
               if (remain_ff == 5'd0) begin
                  res_run_last = 1'b1;
                  res_done     = last_pend_ff;
                  res_status   = size_bad ? ST_SIZE : ST_OK;
                  end_elem     = 1'b1;
                  clear_stream = last_pend_ff;
                  state_in     = S_IDLE;
               end else begin
                  res_run_last = 1'b0;
                  remain_in    = remain_ff - 5'd1;
                  state_in     = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (end_elem) begin
         if (over) begin
            stopped_in = 1'b1;
            error_in   = ST_SIZE;
         end else begin
            flag_shift_in = flag_shift_ff >> 1;
            pos_in        = pos_ff + 3'd1;
            phase_in      = (pos_ff == 3'd7) ? PH_FLAG : PH_ELEM;
         end
      end

      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{out_byte:   res_byte,
                          byte_valid: res_bv,
                          run_last:   res_run_last,
                          done_res:   res_done,
                          status:     res_done ? res_status : ST_OK};
      end

      // The history and the configuration registers are kept across streams; the decoding state starts over.
      if (clear_stream) begin
         phase_in      = PH_FLAG;
         flag_shift_in = 8'd0;
         raw_flag_in   = 8'd0;
         pos_in        = 3'd0;
         tok_lo_in     = 8'd0;
         count_in      = '0;
         error_in      = ST_OK;
         stopped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_FLAG;
         flag_shift_ff <= 8'd0;
         raw_flag_ff   <= 8'd0;
         pos_ff        <= 3'd0;
         tok_lo_ff     <= 8'd0;
         count_ff      <= '0;
         error_ff      <= ST_OK;
         stopped_ff    <= 1'b0;
         keyed_ff      <= 1'b0;
         expected_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         flag_shift_ff <= flag_shift_in;
         raw_flag_ff   <= raw_flag_in;
         pos_ff        <= pos_in;
         tok_lo_ff     <= tok_lo_in;
         count_ff      <= count_in;
         error_ff      <= error_in;
         stopped_ff    <= stopped_in;
         keyed_ff      <= keyed_in;
         expected_ff   <= expected_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      src_ff       <= src_in;
      remain_ff    <= remain_in;
      last_pend_ff <= last_pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // History window: written at the output position, read at the copy source.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[count_ff[WIN_AW-1:0]] <= hist_wdata;
      end
      if (state_ff == S_READ) begin
         rd_data_ff <= hist_mem[src_ff];
      end
   end

   a_copy_not_stopped: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !stopped_ff)
      else $error("copy in progress while decoding is stopped");

   a_write_emits: assert property (@(posedge clock) disable iff (reset)
      hist_we |=> (rsp_valid_ff && rsp_data_ff.byte_valid))
      else $error("history write without a matching data response");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_done) |=> (count_ff == '0 && !stopped_ff && phase_ff == PH_FLAG))
      else $error("stream state not cleared after done");

   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.byte_valid) |-> rsp_data_ff.done_res)
      else $error("response without a byte that is not a done response");

endmodule
